// File: src/sha1_pkg.sv
// Shared types and constants for the SHA-1 digest block.
package sha1_pkg;

	typedef enum logic [1:0] {
		OP_ABSORB = 2'd0,
		OP_DIGEST = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam int unsigned ROUNDS = 80;
	localparam int unsigned DIGEST_WORDS = 5;

	typedef logic [31:0] word_t;

	function automatic word_t round_k(input logic [6:0] t);
		if (t < 7'd20) return K0;
		else if (t < 7'd40) return K1;
		else if (t < 7'd60) return K2;
		else return K3;
	endfunction

	function automatic word_t round_f(input logic [6:0] t, input word_t b, input word_t c,
			input word_t d);
		if (t < 7'd20) return (b & c) | (~b & d);
		else if (t < 7'd40) return b ^ c ^ d;
		else if (t < 7'd60) return (b & c) | ((b | c) & d);
		else return b ^ c ^ d;
	endfunction

endpackage

// File: src/sha1_message_digest.sv
// SHA-1 digest top level: byte intake, padding sequencer and one shared round unit.
//
// The block hashes a byte stream one item at a time. An absorb item packs one
// byte big-endian into the 16-word block register; an item that completes a
// 64-byte block copies that register into the schedule window and starts the
// compression, which runs one SHA-1 round per cycle on a single shared round
// unit, followed by the chaining add. Other absorb items start no compression.
// A digest item snapshots the chaining words and the partial block, pads it
// with 0x80, zeros and the 64-bit bit count, and runs one or two compressions
// (two when 56 or more bytes are pending; the second block is loaded in a
// reload step after the first add) on a scratch copy so that the running hash
// is left as it was; it then emits five items, word 0 first, one per cycle
// while the output is not stalled. A clear item reloads the initial chaining
// words and zeroes the byte count. Code 3 is dropped. stall is high whenever
// the block is busy; a finished digest word is held in an output register
// until taken.
module sha1_message_digest
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,   // one round per cycle
		ST_ADD,     // add work regs into target chain
		ST_PAD2,    // load second padding block
		ST_EMIT     // present digest words
	} state_t;

	state_t      state_q;
	word_t       chain_q [5];     // running chaining words
	word_t       hd_q [5];        // scratch chain for digest
	word_t       win_q [16];      // schedule window
	word_t       blk_q [16];      // block buffer, filled during absorb
	word_t       wr_q [5];        // a..e
	logic [63:0] count_q;
	logic [6:0]  t_q;
	logic        dig_q;           // compression belongs to a digest
	logic        two_q;           // digest needs a second block
	logic [2:0]  idx_q;
	logic        ov_q;
	word_t       ow_q;

	logic  accept;
	op_t   op;
	logic [5:0] fill;
	word_t wnew, wcur, tmp;
	word_t pb [16];
	logic [63:0] bits;

	assign op     = op_t'(operation);
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign fill   = count_q[5:0];
	assign bits   = {count_q[60:0], 3'b000};

	// Schedule expansion over the rotating window
	assign wnew = {win_q[(t_q[3:0] + 4'd13)] ^ win_q[(t_q[3:0] + 4'd8)]
		^ win_q[(t_q[3:0] + 4'd2)] ^ win_q[t_q[3:0]]};
	assign wcur = (t_q < 7'd16) ? win_q[t_q[3:0]] : {wnew[30:0], wnew[31]};
	assign tmp  = {wr_q[0][26:0], wr_q[0][31:27]} + round_f(t_q, wr_q[1], wr_q[2], wr_q[3])
		+ wr_q[4] + wcur + round_k(t_q);

	// First padding block built from the block buffer: keep bytes below fill,
	// put the pad byte at fill, zero the rest, length in the tail if it fits.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			for (int j = 0; j < 4; j++) begin
				if (6'(4 * i + j) < fill)
					pb[i][31 - 8 * j -: 8] = blk_q[i][31 - 8 * j -: 8];
				else if (6'(4 * i + j) == fill)
					pb[i][31 - 8 * j -: 8] = PAD_BYTE;
				else
					pb[i][31 - 8 * j -: 8] = 8'h00;
			end
		end
		if (fill < 6'd56) begin
			pb[14] = bits[63:32];
			pb[15] = bits[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chain_q <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
			count_q <= '0;
			t_q     <= '0;
			dig_q   <= 1'b0;
			two_q   <= 1'b0;
			idx_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_ABSORB: begin
								blk_q[fill[5:2]][31 - 8 * fill[1:0] -: 8] <= data_byte;
								count_q <= count_q + 64'd1;
								if (fill == 6'd63) begin
									for (int i = 0; i < 15; i++) win_q[i] <= blk_q[i];
									win_q[15] <= {blk_q[15][31:8], data_byte};
									wr_q  <= chain_q;
									t_q   <= '0;
									dig_q <= 1'b0;
									state_q <= ST_ROUND;
								end
							end
							OP_CLEAR: begin
								chain_q <= '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
								count_q <= '0;
							end
							OP_DIGEST: begin
								win_q <= pb;
								wr_q  <= chain_q;
								hd_q  <= chain_q;
								two_q <= (fill > 6'd55);
								t_q   <= '0;
								dig_q <= 1'b1;
								state_q <= ST_ROUND;
							end
							default: ;
						endcase
					end
				end
				ST_ROUND: begin
					if (t_q >= 7'd16) win_q[t_q[3:0]] <= {wnew[30:0], wnew[31]};
					wr_q[4] <= wr_q[3];
					wr_q[3] <= wr_q[2];
					wr_q[2] <= {wr_q[1][1:0], wr_q[1][31:2]};
					wr_q[1] <= wr_q[0];
					wr_q[0] <= tmp;
					t_q <= t_q + 7'd1;
					if (t_q == 7'(ROUNDS - 1)) state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (!dig_q) begin
						for (int i = 0; i < 5; i++) chain_q[i] <= chain_q[i] + wr_q[i];
						state_q <= ST_IDLE;
					end else begin
						for (int i = 0; i < 5; i++) hd_q[i] <= hd_q[i] + wr_q[i];
						state_q <= two_q ? ST_PAD2 : ST_EMIT;
						if (!two_q) begin
							ov_q  <= 1'b1;
							idx_q <= '0;
							ow_q  <= hd_q[0] + wr_q[0];
						end
					end
				end
				ST_PAD2: begin
					for (int i = 0; i < 14; i++) win_q[i] <= '0;
					win_q[14] <= bits[63:32];
					win_q[15] <= bits[31:0];
					wr_q  <= hd_q;
					two_q <= 1'b0;
					t_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_EMIT: begin
					if (!out_stall) begin
						if (idx_q == 3'(DIGEST_WORDS - 1)) begin
							ov_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
							ow_q  <= hd_q[idx_q + 3'd1];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = ov_q;
	assign digest_word = ow_q;
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'(DIGEST_WORDS - 1));

	// Words leave only while emitting.
	a_emit_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_EMIT) else $error("output valid outside emit");
	// Round counter stays in range.
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> t_q < 7'(ROUNDS)) else $error("round counter overrun");
	// Index advances by one after each taken word.
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_word |=> word_index == $past(word_index) + 3'd1)
		else $error("word index skipped");
	// A digest leaves the running count untouched.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |=> $stable(count_q)) else $error("count changed during emit");

endmodule

// File: bench/sha1_message_digest_tb.sv
// Self-checking testbench for the byte-serial SHA-1 digest block.
`timescale 1ns / 1ps

module sha1_message_digest_tb;
	import sha1_pkg::*;

	// Expected digest word as it leaves the block.
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_item_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	// Predictor state: chaining words, byte count and the partial block.
	logic [31:0] chain_h [5];
	logic [63:0] bytes_seen;
	logic [7:0]  pending_block [64];

	digest_item_t expected_words [$];
	int          error_count;
	int          words_checked;
	int          items_sent;
	int          digests_sent;
	bit          sender_idles;
	bit          receiver_idles;
	int          receiver_hold;

	sha1_message_digest dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digest_word(digest_word),
		.word_index (word_index),
		.last_word  (last_word)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// Run the 80 SHA-1 rounds over one block and add into h.
	task automatic sha1_compress(inout logic [31:0] h [5], input logic [7:0] blk [64]);
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, wt, sum;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
		for (int t = 0; t < 80; t++) begin
			if (t >= 16) begin
				wt = rol(w[(t+13)%16] ^ w[(t+8)%16] ^ w[(t+2)%16] ^ w[t%16], 1);
				w[t%16] = wt;
			end else begin
				wt = w[t];
			end
			if (t < 20) begin
				f = (b & c) | (~b & d); k = K0;
			end else if (t < 40) begin
				f = b ^ c ^ d; k = K1;
			end else if (t < 60) begin
				f = (b & c) | ((b | c) & d); k = K2;
			end else begin
				f = b ^ c ^ d; k = K3;
			end
			sum = rol(a, 5) + f + e + wt + k;
			e = d; d = c; c = rol(b, 30); b = a; a = sum;
		end
		h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
	endtask

	function automatic void clear_hash();
		chain_h = '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
		bytes_seen = '0;
	endfunction

	// Advance the predictor by one accepted item; queue any digest words.
	task automatic predict_item(input logic [1:0] op, input logic [7:0] value);
		logic [31:0] h [5];
		logic [7:0]  blk [64];
		logic [63:0] bits;
		int          fill;
		digest_item_t dw;
		fill = int'(bytes_seen[5:0]);
		case (op_t'(op))
			OP_ABSORB: begin
				pending_block[fill] = value;
				bytes_seen++;
				if (fill == 63)
					sha1_compress(chain_h, pending_block);
			end
			OP_CLEAR: clear_hash();
			OP_DIGEST: begin
				h = chain_h;
				bits = bytes_seen << 3;
				for (int i = 0; i < 64; i++)
					blk[i] = (i < fill) ? pending_block[i] : 8'h00;
				blk[fill] = PAD_BYTE;
				if (fill > 55) begin
					sha1_compress(h, blk);
					for (int i = 0; i < 64; i++)
						blk[i] = 8'h00;
				end
				for (int i = 0; i < 8; i++)
					blk[56+i] = bits[63-8*i -: 8];
				sha1_compress(h, blk);
				for (int i = 0; i < 5; i++) begin
					dw.word = h[i];
					dw.index = 3'(i);
					dw.last = (i == 4);
					expected_words.push_back(dw);
				end
			end
			default: ;
		endcase
	endtask

	// Offer one item, hold it until accepted, then update the predictor.
	// Valid stays high after acceptance; the next item replaces or drops it, or a drain drops it.
	task automatic send_item(input logic [1:0] op, input logic [7:0] value);
		while (sender_idles && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		data_byte <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_item(op, value);
		items_sent++;
		if (op == OP_DIGEST)
			digests_sent++;
	endtask

	// Wait until every queued digest word has been taken.
	task automatic drain_results();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (expected_words.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
	endtask

	task automatic send_bytes(input int count);
		for (int i = 0; i < count; i++)
			send_item(OP_ABSORB, 8'($urandom_range(255)));
	endtask

	// Directed: empty message, byte extremes, unused code and clears.
	task automatic test_directed();
		send_item(OP_DIGEST, 8'hFF);
		send_item(OP_ABSORB, 8'h00);
		send_item(OP_ABSORB, 8'hFF);
		send_item(OP_ABSORB, 8'hA5);
		send_item(OP_NONE, 8'h5A);
		send_item(OP_DIGEST, 8'h00);
		send_item(OP_CLEAR, 8'hFF);
		send_item(OP_DIGEST, 8'h00);
		send_item(OP_CLEAR, 8'h00);
		drain_results();
	endtask

	// Padding boundaries: 55, 56, 63, 64 bytes, digest in the middle of a stream.
	task automatic test_pad_edges();
		int lengths [4] = '{55, 56, 63, 64};
		foreach (lengths[n]) begin
			send_item(OP_CLEAR, 8'h00);
			send_bytes(lengths[n]);
			send_item(OP_DIGEST, 8'h00);
		end
		send_bytes(10);
		send_item(OP_DIGEST, 8'h00);
		drain_results();
	endtask

	// Hold the output off for a long stretch while more items are offered behind it.
	task automatic test_backpressure();
		receiver_hold = 600;
		send_item(OP_CLEAR, 8'h00);
		for (int i = 0; i < 4; i++) begin
			send_bytes(3);
			send_item(OP_DIGEST, 8'h00);
		end
		drain_results();
	endtask

	// Random traffic: mostly byte runs with digests, some clears and unused codes.
	task automatic test_random();
		int r;
		send_item(OP_CLEAR, 8'h00);
		for (int i = 0; i < 125; i++) begin
			// a quiet stretch with no idling on either side
			sender_idles = !(i >= 40 && i < 100);
			receiver_idles = sender_idles;
			r = $urandom_range(99);
			if (r < 80)
				send_item(OP_ABSORB, 8'($urandom_range(255)));
			else if (r < 93)
				send_item(OP_DIGEST, 8'($urandom_range(255)));
			else if (r < 97)
				send_item(OP_CLEAR, 8'($urandom_range(255)));
			else
				send_item(OP_NONE, 8'($urandom_range(255)));
		end
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		send_item(OP_DIGEST, 8'h00);
		drain_results();
	endtask

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else if (receiver_hold > 0) begin
			receiver_hold <= receiver_hold - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= receiver_idles && ($urandom_range(99) < 20);
		end
	end

	// Compare each accepted digest word with the oldest expectation.
	always @(posedge clk) begin
		digest_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word %h idx %0d", $time, digest_word, word_index);
				error_count++;
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (digest_word !== want.word) begin
					$display("%0t: digest_word expected %h actual %h", $time, want.word,
						digest_word);
					error_count++;
				end
				if (word_index !== want.index) begin
					$display("%0t: word_index expected %0d actual %0d", $time, want.index,
						word_index);
					error_count++;
				end
				if (last_word !== want.last) begin
					$display("%0t: last_word expected %0d actual %0d", $time, want.last,
						last_word);
					error_count++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("sha1_message_digest: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ABSORB;
		data_byte = 8'h00;
		error_count = 0;
		words_checked = 0;
		items_sent = 0;
		digests_sent = 0;
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		receiver_hold = 0;
		clear_hash();
		for (int i = 0; i < 64; i++)
			pending_block[i] = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pad_edges();
		test_backpressure();
		test_random();

		if (expected_words.size() != 0) begin
			$display("%0t: %0d digest words never arrived", $time, expected_words.size());
			error_count++;
		end
		$display("Covered %0d items with %0d digest requests, %0d words checked,",
			items_sent, digests_sent, words_checked);
		$display("including pad edges, clears, unused code and a long output hold-off.");
		if (error_count == 0)
			$display("sha1_message_digest: match");
		else
			$display("sha1_message_digest: mismatch");
		$finish;
	end

endmodule

// File: files.f
src/sha1_pkg.sv
src/sha1_message_digest.sv
bench/sha1_message_digest_tb.sv
